// File: rtl/core/pcb_pkg.sv
// Shared types and constants for the plane crossing bounding box core.
// No dependencies; imported by every module of the core.
package pcb_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int CNT_W     = 5;
  localparam int IN_TDATA_W  = 6 * DATA_W;
  localparam int OUT_TDATA_W = 4 * DATA_W;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_X_P = 2'd0,  // start_x * end_z
    MUL_X_Q = 2'd1,  // start_z * end_x
    MUL_Y_P = 2'd2,  // start_y * end_z
    MUL_Y_Q = 2'd3   // start_z * end_y
  } mul_sel_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_UPD  = 5'b10000
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     div_step;
    logic     load_out;
  } ctrl_cmd_t;

endpackage

// File: rtl/core/pcb_div.sv
// One divider lane: takes numerator and denominator, forms the saturated,
// truncated quotient over 32 restoring steps. Depends on pcb_pkg.
module pcb_div
  import pcb_pkg::*;
(
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  input  logic signed [PROD_W:0]     num,
  input  logic signed [DATA_W:0]     den,
  output logic signed [DATA_W-1:0]   quo
);

  logic                neg_r, neg_nxt;
  logic                sat_r, sat_nxt;
  logic [DATA_W:0]     dmag_r, dmag_nxt;
  logic [DATA_W:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]   lo_r, lo_nxt;

  logic [PROD_W:0]     nabs;
  logic [PROD_W-1:0]   nmag;
  logic [DATA_W:0]     dabs;
  logic [DATA_W+1:0]   trial;
  logic                ge;

  always_comb begin
    nabs  = num[PROD_W] ? (PROD_W+1)'(-num) : num;
    nmag  = nabs[PROD_W-1:0];
    dabs  = den[DATA_W] ? (DATA_W+1)'(-den) : den;
    trial = {rem_r, lo_r[DATA_W-1]};
    ge    = trial >= {1'b0, dmag_r};

    neg_nxt  = neg_r;
    sat_nxt  = sat_r;
    dmag_nxt = dmag_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    if (start) begin
      neg_nxt  = num[PROD_W] ^ den[DATA_W];
      // quotient of 2^32 or more saturates either way
      sat_nxt  = {1'b0, nmag} >= {dabs, {DATA_W{1'b0}}};
      dmag_nxt = dabs;
      rem_nxt  = {1'b0, nmag[PROD_W-1:DATA_W]};
      lo_nxt   = nmag[DATA_W-1:0];
    end else if (step) begin
      rem_nxt = ge ? (DATA_W+1)'(trial - {1'b0, dmag_r}) : trial[DATA_W:0];
      lo_nxt  = {lo_r[DATA_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    sat_r  <= sat_nxt;
    dmag_r <= dmag_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
  end

  always_comb begin
    if (sat_r) begin
      quo = neg_r ? S32_MIN : S32_MAX;
    end else if (neg_r) begin
      quo = lo_r[DATA_W-1] ? S32_MIN : -$signed(lo_r);
    end else begin
      quo = lo_r[DATA_W-1] ? S32_MAX : $signed(lo_r);
    end
  end

endmodule

// File: rtl/core/pcb_dp.sv
// Datapath: input registers, shared multiplier, two divider lanes,
// running box and output register. Depends on pcb_pkg and pcb_div.
module pcb_dp
  import pcb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_cmd_t                 cmd,
  input  logic [IN_TDATA_W-1:0]     in_tdata,
  input  logic                      in_tuser,
  output logic [OUT_TDATA_W-1:0]    out_tdata,
  output logic [1:0]                out_tuser
);

  logic signed [DATA_W-1:0] sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;
  logic                     clr_r;
  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic signed [PROD_W:0]   num_x, num_y;
  logic signed [DATA_W:0]   den;
  logic signed [DATA_W-1:0] cx, cy;
  logic                     crossed;

  logic signed [DATA_W-1:0] lx_r, hx_r, ly_r, hy_r;
  logic signed [DATA_W-1:0] lx_nxt, hx_nxt, ly_nxt, hy_nxt;
  logic                     seen_r, seen_nxt;
  logic [OUT_TDATA_W-1:0]   odata_r;
  logic [1:0]               ouser_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sx_r  <= in_tdata[0*DATA_W +: DATA_W];
      sy_r  <= in_tdata[1*DATA_W +: DATA_W];
      sz_r  <= in_tdata[2*DATA_W +: DATA_W];
      ex_r  <= in_tdata[3*DATA_W +: DATA_W];
      ey_r  <= in_tdata[4*DATA_W +: DATA_W];
      ez_r  <= in_tdata[5*DATA_W +: DATA_W];
      clr_r <= in_tuser;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_X_P: begin mul_a = sx_r; mul_b = ez_r; end
      MUL_X_Q: begin mul_a = sz_r; mul_b = ex_r; end
      MUL_Y_P: begin mul_a = sy_r; mul_b = ez_r; end
      MUL_Y_Q: begin mul_a = sz_r; mul_b = ey_r; end
      default: begin mul_a = sx_r; mul_b = ez_r; end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r[cmd.mul_sel] <= mul_p;
    end
  end

  assign num_x = {prod_r[0][PROD_W-1], prod_r[0]} - {prod_r[1][PROD_W-1], prod_r[1]};
  assign num_y = {prod_r[2][PROD_W-1], prod_r[2]} - {prod_r[3][PROD_W-1], prod_r[3]};
  assign den   = {ez_r[DATA_W-1], ez_r} - {sz_r[DATA_W-1], sz_r};

  pcb_div u_div_x (
    .clk   (clk),
    .start (cmd.div_start),
    .step  (cmd.div_step),
    .num   (num_x),
    .den   (den),
    .quo   (cx)
  );

  pcb_div u_div_y (
    .clk   (clk),
    .start (cmd.div_start),
    .step  (cmd.div_step),
    .num   (num_y),
    .den   (den),
    .quo   (cy)
  );

  // touching the plane at one end counts; equal z never does
  assign crossed = (sz_r != ez_r) &&
                   ((sz_r <= 0 && ez_r >= 0) || (sz_r >= 0 && ez_r <= 0));

  always_comb begin
    if (clr_r) begin
      lx_nxt   = S32_MAX;
      hx_nxt   = S32_MIN;
      ly_nxt   = S32_MAX;
      hy_nxt   = S32_MIN;
      seen_nxt = 1'b0;
    end else begin
      lx_nxt   = lx_r;
      hx_nxt   = hx_r;
      ly_nxt   = ly_r;
      hy_nxt   = hy_r;
      seen_nxt = seen_r;
    end
    if (crossed) begin
      if (cx < lx_nxt) lx_nxt = cx;
      if (cx > hx_nxt) hx_nxt = cx;
      if (cy < ly_nxt) ly_nxt = cy;
      if (cy > hy_nxt) hy_nxt = cy;
      seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r   <= S32_MAX;
      hx_r   <= S32_MIN;
      ly_r   <= S32_MAX;
      hy_r   <= S32_MIN;
      seen_r <= 1'b0;
    end else if (cmd.load_out) begin
      lx_r   <= lx_nxt;
      hx_r   <= hx_nxt;
      ly_r   <= ly_nxt;
      hy_r   <= hy_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      odata_r <= {hy_nxt, ly_nxt, hx_nxt, lx_nxt};
      ouser_r <= {seen_nxt, crossed};
    end
  end

  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;

endmodule

// File: rtl/core/pcb_ctrl.sv
// Controller state machine: handshakes and sequencing of multiply,
// divide and box update. Depends on pcb_pkg.
module pcb_ctrl
  import pcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output ctrl_cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              out_free;

  assign out_free = !ovalid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = mul_sel_t'(cnt_r[1:0]);
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ovalid_nxt = ovalid_r;
    if (cmd.load_out)    ovalid_nxt = 1'b1;
    else if (out_tready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

// File: rtl/core/plane_crossing_bounds_core.sv
// Plane crossing bounding box core: tracks where segments cross z=0.
// Depends on pcb_pkg, pcb_ctrl, pcb_dp.
//
// Input channel: one request per segment, two endpoints in signed Q15.16.
// in_tuser set clears the running box before the segment is handled.
// Output channel: one result per request with the crossing flag, the
// box-valid flag and the current box (min/max of crossing x and y).
// Crossings are (x1*z2 - z1*x2)/(z2 - z1), truncated, saturated to 32 bits.
//
// A request passes through 4 multiplies on one shared 32x32 multiplier,
// 1 setup step, 32 restoring divide steps run for x and y in two lanes
// and 1 box update before out_tvalid rises. One request is in flight at
// a time, and a new request is accepted only in the idle state.
// The result sits in an output register, so the next request is taken
// while it waits; if the receiver stalls, the following result is held in
// the update step until the output register frees up.
// Reset (rst_n low, synchronous) empties the box and drops out_tvalid.
module plane_crossing_bounds_core
  import pcb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // new_box
  input  logic                    in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // box_min_x, box_max_x, box_min_y, box_max_y
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  // crossed, box_valid
  output logic [1:0]              out_tuser
);

  ctrl_cmd_t cmd;

  pcb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pcb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// File: rtl/core/pcb_checker.sv
// Port-level checks for plane_crossing_bounds_core, attached by bind.
// Depends on pcb_pkg.
module pcb_port_checks
  import pcb_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_tvalid,
  input logic                    in_tready,
  input logic                    out_tvalid,
  input logic                    out_tready,
  input logic [OUT_TDATA_W-1:0]  out_tdata,
  input logic [1:0]              out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  a_cross_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("crossing reported with empty box");

  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |->
      out_tdata[31:0] == 32'h7FFF_FFFF && out_tdata[63:32] == 32'h8000_0000 &&
      out_tdata[95:64] == 32'h7FFF_FFFF && out_tdata[127:96] == 32'h8000_0000)
    else $error("empty box not at reset values");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      $signed(out_tdata[31:0]) <= $signed(out_tdata[63:32]) &&
      $signed(out_tdata[95:64]) <= $signed(out_tdata[127:96]))
    else $error("box min above max");

endmodule

bind plane_crossing_bounds_core pcb_port_checks u_pcb_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: test/pcb_checker.sv
// Checker for plane_crossing_bounds_core: watches both stream channels, predicts each
// result from the accepted segment and compares it field by field.
// Depends on pcb_pkg for the channel widths and the saturation bounds.
module pcb_checker
  import pcb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,
  output int                     mismatches,
  output int                     outstanding,
  output int                     checked,
  output int                     crossings
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                     crossed;
    logic                     box_valid;
    logic signed [DATA_W-1:0] min_x;
    logic signed [DATA_W-1:0] max_x;
    logic signed [DATA_W-1:0] min_y;
    logic signed [DATA_W-1:0] max_y;
  } box_report_t;

  logic signed [DATA_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                     any_cross;
  box_report_t              expected_boxes[$];
  box_report_t              want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
    crossings   = 0;
  end

  // interpolated coordinate at z=0, truncated toward zero, saturated to 32 bits
  function automatic logic signed [DATA_W-1:0] plane_coord(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] za,
    input logic signed [DATA_W-1:0] b,
    input logic signed [DATA_W-1:0] zb
  );
    logic signed [64:0] num;
    logic signed [32:0] den;
    logic [64:0]        nmag;
    logic [64:0]        dmag;
    logic [64:0]        quo;
    logic               neg;
    num  = 65'(a) * 65'(zb) - 65'(za) * 65'(b);
    den  = 33'(zb) - 33'(za);
    nmag = (num < 0) ? -num : num;
    dmag = (den < 0) ? 65'(-den) : 65'(den);
    if (dmag == 0) return '0;
    quo = nmag / dmag;
    neg = (num < 0) != (den < 0);
    if (quo == 0) return '0;
    if (neg) begin
      if (quo >= 65'h8000_0000) return S32_MIN;
      return -$signed(quo[DATA_W-1:0]);
    end
    if (quo > 65'h7FFF_FFFF) return S32_MAX;
    return $signed(quo[DATA_W-1:0]);
  endfunction

  task automatic track_segment(input logic [IN_TDATA_W-1:0] seg, input logic clear);
    logic signed [DATA_W-1:0] x1, y1, z1, x2, y2, z2, cx, cy;
    logic                     hit;
    box_report_t              rep;
    {z2, y2, x2, z1, y1, x1} = seg;
    if (clear) begin
      lo_x = S32_MAX; hi_x = S32_MIN;
      lo_y = S32_MAX; hi_y = S32_MIN;
      any_cross = 1'b0;
    end
    hit = (z1 != z2) && ((z1 <= 0 && z2 >= 0) || (z1 >= 0 && z2 <= 0));
    if (hit) begin
      cx = plane_coord(x1, z1, x2, z2);
      cy = plane_coord(y1, z1, y2, z2);
      if (cx < lo_x) lo_x = cx;
      if (cx > hi_x) hi_x = cx;
      if (cy < lo_y) lo_y = cy;
      if (cy > hi_y) hi_y = cy;
      any_cross = 1'b1;
    end
    rep.crossed   = hit;
    rep.box_valid = any_cross;
    rep.min_x     = lo_x;
    rep.max_x     = hi_x;
    rep.min_y     = lo_y;
    rep.max_y     = hi_y;
    expected_boxes.push_back(rep);
  endtask

  task automatic check_field(input string name, input logic signed [DATA_W-1:0] exp_v,
                             input logic signed [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lo_x = S32_MAX; hi_x = S32_MIN;
      lo_y = S32_MAX; hi_y = S32_MIN;
      any_cross = 1'b0;
      expected_boxes.delete();
    end else begin
      if (in_tvalid && in_tready) track_segment(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_boxes.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = expected_boxes.pop_front();
          check_field("crossed",   32'(want.crossed),   32'(out_tuser[0]));
          check_field("box_valid", 32'(want.box_valid), 32'(out_tuser[1]));
          check_field("box_min_x", want.min_x, out_tdata[0*DATA_W +: DATA_W]);
          check_field("box_max_x", want.max_x, out_tdata[1*DATA_W +: DATA_W]);
          check_field("box_min_y", want.min_y, out_tdata[2*DATA_W +: DATA_W]);
          check_field("box_max_y", want.max_y, out_tdata[3*DATA_W +: DATA_W]);
          checked++;
          if (want.crossed) crossings++;
        end
      end
    end
    outstanding <= expected_boxes.size();
  end

endmodule

// File: test/tb_plane_crossing_bounds_core.sv
// Top-level testbench for plane_crossing_bounds_core: drives segment requests
// under several idle/stall patterns and gives the verdict. Depends on pcb_pkg,
// pcb_checker and the core RTL.
module tb_plane_crossing_bounds_core
  import pcb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_SEGS  = 335;  // per idle/stall phase
  localparam int DRAIN_CYCLES = 60;

  localparam logic signed [DATA_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] ZERO = 32'sh0000_0000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  int mismatches, outstanding, checked, crossings;
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;
  int cycles    = 0;

  always #5 clk = ~clk;

  plane_crossing_bounds_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pcb_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .crossings   (crossings)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid stays high across back-to-back requests; it drops only for an idle gap
  task automatic send_segment(input logic signed [DATA_W-1:0] sx, sy, sz, ex, ey, ez,
                              input logic clear);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ez, ey, ex, sz, sy, sx};
    in_tuser  <= clear;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_coord();
    case ($urandom_range(9))
      6, 7:    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      8: begin
        case ($urandom_range(3))
          0:       return S32_MIN;
          1:       return S32_MAX;
          2:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      9:       return ZERO;
      default: return $signed($urandom());
    endcase
  endfunction

  // mostly opposite-sign z pairs so most segments cross the plane
  task automatic pick_plane_z(output logic signed [DATA_W-1:0] z1, z2);
    logic signed [DATA_W-1:0] a, b;
    a = pick_coord();
    b = pick_coord();
    if (a < 0) a = -(a + 1);
    if (b < 0) b = -(b + 1);
    case ($urandom_range(9))
      0, 1, 2, 3: begin z1 = -a - 1; z2 = b; end
      4, 5:       begin z1 = a; z2 = -b - 1; end
      6:          begin z1 = ZERO; z2 = pick_coord(); end
      7:          begin z1 = pick_coord(); z2 = z1; end
      8:          begin z1 = a; z2 = b; end
      default:    begin z1 = pick_coord(); z2 = pick_coord(); end
    endcase
    if ($urandom_range(1)) {z1, z2} = {z2, z1};
  endtask

  task automatic send_random_segment();
    logic signed [DATA_W-1:0] z1, z2;
    pick_plane_z(z1, z2);
    send_segment(pick_coord(), pick_coord(), z1, pick_coord(), pick_coord(), z2,
                 $urandom_range(11) == 0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty box, both ends above the plane
    send_segment(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 1'b0);
    // same strict negative sign
    send_segment(ONE, ONE, -ONE, 2 * ONE, 2 * ONE, -3 * ONE, 1'b0);
    // both ends on the plane: equal z never crosses
    send_segment(ONE, ONE, ZERO, 5 * ONE, 5 * ONE, ZERO, 1'b0);
    // one endpoint on the plane
    send_segment(3 * ONE, -4 * ONE, ZERO, 7 * ONE, 9 * ONE, 5 * ONE, 1'b0);
    send_segment(-2 * ONE, 6 * ONE, -ONE, 11 * ONE, -8 * ONE, ZERO, 1'b0);
    // plain crossings widening the box
    send_segment(ZERO, ZERO, -ONE, 4 * ONE, 4 * ONE, ONE, 1'b0);
    send_segment(-10 * ONE, 12 * ONE, 2 * ONE, -20 * ONE, 30 * ONE, -2 * ONE, 1'b0);
    // truncation toward zero on both signs
    send_segment(-32'sd3, 32'sd3, -32'sd1, 32'sd0, 32'sd0, 32'sd2, 1'b0);
    send_segment(32'sd7, -32'sd7, 32'sd2, 32'sd0, 32'sd0, -32'sd1, 1'b0);
    // clear then a non-crossing segment leaves the box empty
    send_segment(ONE, ONE, ONE, ONE, ONE, 2 * ONE, 1'b1);
    // clear and cross in the same request
    send_segment(5 * ONE, 5 * ONE, -ONE, 5 * ONE, 5 * ONE, ONE, 1'b1);
    // extremes of the fields
    send_segment(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 1'b0);
    send_segment(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, 1'b0);
    send_segment(S32_MAX, S32_MAX, -32'sd1, S32_MAX, S32_MAX, 32'sd1, 1'b0);
    send_segment(S32_MIN, S32_MIN, 32'sd1, S32_MIN, S32_MIN, -32'sd1, 1'b0);
    send_segment(S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX, ZERO, 1'b0);
    send_segment(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, ZERO, 1'b1);
    send_segment(ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1);
    send_segment(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0);
    send_segment(ZERO, ZERO, S32_MAX, ZERO, ZERO, S32_MIN, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 88; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      repeat (RANDOM_SEGS) send_random_segment();
    end
    in_tvalid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d segments sent, %0d results checked, %0d of them crossing z=0",
             sent, checked, crossings);
    $display("idle/stall patterns: none, sender 88%%, receiver 88%%, both 19%%");
    if (mismatches == 0 && outstanding == 0 && checked == sent) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
